@@ rtl/core/rtods_pkg.sv @@
package rtods_pkg;

  localparam int unsigned RelayCountDef = 4;
  localparam int unsigned RelayIdxW     = 2;
  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned PlanW         = 46;
  localparam int unsigned EdgeW         = 11;
  localparam int unsigned MinW          = 11;
  localparam int unsigned PerW          = 12;
  localparam int unsigned YearW         = 8;

  localparam logic [YearW-1:0] ValidYear  = 8'd124;
  localparam logic [1:0]       ModeNone   = 2'd0;
  localparam logic [1:0]       ModeWindow = 2'd1;
  localparam logic [1:0]       ModeCycle  = 2'd2;

  typedef enum logic [1:0] {
    ActLeave = 2'd0,
    ActOff   = 2'd1,
    ActOn    = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StDiv,
    StEmit
  } state_e;

  typedef struct packed {
    logic [YearW-1:0] year_since_1900;
    logic [4:0]       hour_of_day;
    logic [5:0]       minute_of_hour;
  } in_t;

  typedef struct packed {
    logic [RelayIdxW-1:0] relay_index;
    logic                 claimed;
    act_e                 action;
    logic                 last_relay;
  } out_t;

  typedef struct packed {
    logic            start;
    logic [MinW-1:0] dividend;
    logic [PerW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PerW-1:0] remainder;
  } rem_rsp_t;

endpackage

@@ rtl/core/rtods_rem.sv @@
module rtods_rem
  import rtods_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rem_req_t req_i,
  output rem_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(MinW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PerW-1:0] rem_q, rem_d;
  logic [MinW-1:0] dvd_q, dvd_d;
  logic [PerW-1:0] dvs_q, dvs_d;
  logic [PerW:0]   shifted;
  logic [PerW:0]   diff;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    shifted = {rem_q, dvd_q[MinW-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MinW);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[PerW-1:0];
      end else begin
        rem_d = shifted[PerW-1:0];
      end
      dvd_d = {dvd_q[MinW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      dvs_q  <= dvs_d;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("Remainder unit started while busy.");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("Remainder done without a preceding run.");

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dvs_q != '0) |-> rem_q < dvs_q)
    else $error("Remainder not below divisor.");

endmodule

@@ rtl/core/relay_time_of_day_scheduler_core.sv @@
// Relay time-of-day scheduler.
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one clock tick
// transaction: year, hour and minute. For each tick the block returns one
// result transaction per relay on the output channel (out_valid_o,
// out_stall_i, out_data_o), relay 0 first, with last_relay set on the final one.
// The configuration channel writes the plan word of relay cfg_index_i; it is
// always ready, and writes to an index at or above RelayCount are dropped.
// A relay in cycle mode with a valid year and a nonzero period computes the
// minute of day modulo its period on a shared bit-serial remainder unit, one
// quotient bit per cycle, before its result is emitted; any other relay goes
// from evaluation straight to its result. in_stall_o is high from the accept
// until the last result transaction completes. When the receiver stalls, the
// pending result holds on out_data_o and the block waits. Reset clears all
// plan words to zero (no schedule) and returns the block to idle with no
// result pending.
module relay_time_of_day_scheduler_core
  import rtods_pkg::*;
#(
  parameter int unsigned RelayCount = RelayCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PlanW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = (RelayCount > 1) ? $clog2(RelayCount) : 1;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  out_t            out_q, out_d;
  logic [MinW-1:0] mod_q, mod_d;
  logic            ok_q, ok_d;
  logic [PlanW-1:0] plan_q [RelayCount];

  logic [PlanW-1:0] plan;
  logic [1:0]       mode;
  logic [EdgeW-1:0] on_min, off_min, cyc_on, cyc_off;
  logic [PerW-1:0]  period;
  logic [MinW-1:0]  hour_ext;
  logic             last;
  logic             lit;
  act_e             direct_act;
  rem_req_t         rem_req;
  rem_rsp_t         rem_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RelayCount; i++) begin
        plan_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_index_i < CfgIdxW'(RelayCount)) begin
      plan_q[cfg_index_i[IdxW-1:0]] <= cfg_data_i;
    end
  end

  assign plan    = plan_q[idx_q];
  assign mode    = plan[1:0];
  assign on_min  = plan[12:2];
  assign off_min = plan[23:13];
  assign cyc_on  = plan[34:24];
  assign cyc_off = plan[45:35];
  assign period  = PerW'(cyc_on) + PerW'(cyc_off);
  assign last    = (idx_q == IdxW'(RelayCount - 1));

  assign hour_ext = MinW'(in_data_i.hour_of_day);

  always_comb begin
    if (on_min < off_min) begin
      lit = (mod_q >= on_min) && (mod_q < off_min);
    end else begin
      lit = (mod_q >= on_min) || (mod_q < off_min);
    end
    direct_act = ActLeave;
    if (ok_q && mode == ModeWindow && on_min != off_min) begin
      direct_act = lit ? ActOn : ActOff;
    end
  end

  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    out_d            = out_q;
    mod_d            = mod_q;
    ok_d             = ok_q;
    rem_req.start    = 1'b0;
    rem_req.dividend = mod_q;
    rem_req.divisor  = period;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mod_d   = (hour_ext << 6) - (hour_ext << 2) + MinW'(in_data_i.minute_of_hour);
          ok_d    = (in_data_i.year_since_1900 >= ValidYear);
          idx_d   = '0;
          state_d = StEval;
        end
      end
      StEval: begin
        out_d.relay_index = RelayIdxW'(idx_q);
        out_d.claimed     = (mode != ModeNone);
        out_d.last_relay  = last;
        out_d.action      = direct_act;
        if (ok_q && mode == ModeCycle && period != '0) begin
          rem_req.start = 1'b1;
          state_d       = StDiv;
        end else begin
          state_d = StEmit;
        end
      end
      StDiv: begin
        if (rem_rsp.done) begin
          out_d.action = (rem_rsp.remainder < PerW'(cyc_on)) ? ActOn : ActOff;
          state_d      = StEmit;
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          if (last) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = StEval;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      out_q   <= '0;
      mod_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      out_q   <= out_d;
      mod_q   <= mod_d;
      ok_q    <= ok_d;
    end
  end

  rtods_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign out_data_o  = out_q;

  a_last_ends_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_relay) |=> state_q == StIdle)
    else $error("Block did not return to idle after the last result.");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.relay_index <= RelayIdxW'(RelayCount - 1))
    else $error("Result relay index out of range.");

  a_div_only_when_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_req.start |-> ok_q && mode == ModeCycle && period != '0)
    else $error("Remainder unit started for a relay that needs none.");

endmodule

@@ test/tb_relay_time_of_day_scheduler_core.sv @@
module tb_relay_time_of_day_scheduler_core
  import rtods_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRelays     = RelayCountDef;
  localparam int unsigned MinPerHour    = 60;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned WatchdogLimit = 3000;
  localparam logic [1:0]  ModeSpare     = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_t                in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [PlanW-1:0]   cfg_data_i = '0;

  logic [PlanW-1:0] relay_plan [NumRelays];
  out_t             pending_relay_results [$];
  int unsigned      errors = 0;
  int unsigned      idle_cycles = 0;

  int unsigned gap_max = 0;
  int unsigned burst_max = 1;
  int unsigned burst_left = 1;
  int unsigned stall_pct = 0;
  int unsigned stall_max = 1;
  int unsigned stall_run = 0;
  logic        stall_now = 1'b0;

  relay_time_of_day_scheduler_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [PlanW-1:0] make_plan(input logic [1:0] mode,
                                                 input logic [EdgeW-1:0] on_m,
                                                 input logic [EdgeW-1:0] off_m,
                                                 input logic [EdgeW-1:0] cyc_on,
                                                 input logic [EdgeW-1:0] cyc_off);
    return {cyc_off, cyc_on, off_m, on_m, mode};
  endfunction

  function automatic in_t tick_of(input logic [YearW-1:0] year, input logic [4:0] hour,
                                  input logic [5:0] minute);
    in_t tick;
    tick.year_since_1900 = year;
    tick.hour_of_day     = hour;
    tick.minute_of_hour  = minute;
    return tick;
  endfunction

  function automatic act_e relay_action(input logic [PlanW-1:0] plan, input in_t tick);
    int unsigned minute_of_day;
    int unsigned on_m;
    int unsigned off_m;
    int unsigned cyc_on;
    int unsigned period;
    logic [1:0]  mode;
    bit          lit;
    mode          = plan[1:0];
    on_m          = plan[12:2];
    off_m         = plan[23:13];
    cyc_on        = plan[34:24];
    period        = cyc_on + int'(plan[45:35]);
    minute_of_day = int'(tick.hour_of_day) * MinPerHour + int'(tick.minute_of_hour);
    if (tick.year_since_1900 < ValidYear) return ActLeave;
    if (mode == ModeWindow) begin
      if (on_m == off_m) return ActLeave;
      if (on_m < off_m) begin
        lit = (minute_of_day >= on_m) && (minute_of_day < off_m);
      end else begin
        lit = (minute_of_day >= on_m) || (minute_of_day < off_m);
      end
      return lit ? ActOn : ActOff;
    end
    if (mode == ModeCycle) begin
      if (period == 0) return ActLeave;
      return ((minute_of_day % period) < cyc_on) ? ActOn : ActOff;
    end
    return ActLeave;
  endfunction

  function automatic void predict_relay_actions(input in_t tick);
    out_t res;
    for (int r = 0; r < NumRelays; r++) begin
      res.relay_index = RelayIdxW'(r);
      res.claimed     = (relay_plan[r][1:0] != ModeNone);
      res.action      = relay_action(relay_plan[r], tick);
      res.last_relay  = (r == NumRelays - 1);
      pending_relay_results.push_back(res);
    end
  endfunction

  function automatic logic [EdgeW-1:0] random_edge();
    if ($urandom_range(0, 4) == 0) return EdgeW'($urandom_range(0, 2047));
    return EdgeW'($urandom_range(0, 1439));
  endfunction

  function automatic logic [EdgeW-1:0] random_span();
    if ($urandom_range(0, 7) == 0) return EdgeW'($urandom_range(0, 2047));
    return EdgeW'($urandom_range(0, 90));
  endfunction

  function automatic logic [PlanW-1:0] random_plan();
    logic [1:0]       mode;
    logic [EdgeW-1:0] on_m;
    logic [EdgeW-1:0] off_m;
    int unsigned      pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) mode = ModeNone;
    else if (pick == 1) mode = ModeSpare;
    else if (pick < 6) mode = ModeWindow;
    else mode = ModeCycle;
    on_m  = random_edge();
    off_m = ($urandom_range(0, 9) == 0) ? on_m : random_edge();
    if ($urandom_range(0, 19) == 0) return PlanW'({$urandom(), $urandom()});
    return make_plan(mode, on_m, off_m, random_span(), random_span());
  endfunction

  function automatic in_t random_tick();
    in_t tick;
    tick.year_since_1900 = ($urandom_range(0, 5) == 0) ? YearW'($urandom_range(0, 255))
                                                       : YearW'($urandom_range(124, 255));
    tick.hour_of_day     = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(0, 23));
    tick.minute_of_hour  = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, 59));
    return tick;
  endfunction

  task automatic set_idling(input int unsigned gaps, input int unsigned bursts,
                            input int unsigned pct, input int unsigned run);
    gap_max    = gaps;
    burst_max  = bursts;
    burst_left = bursts;
    stall_pct  = pct;
    stall_max  = run;
  endtask

  task automatic send_tick(input in_t tick);
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do @(posedge clk_i); while (in_stall_o);
    predict_relay_actions(tick);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, burst_max);
    end
  endtask

  task automatic wait_results_done();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_relay_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [PlanW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumRelays) relay_plan[idx[RelayIdxW-1:0]] = data;
  endtask

  task automatic load_plans(input logic [PlanW-1:0] p0, input logic [PlanW-1:0] p1,
                            input logic [PlanW-1:0] p2, input logic [PlanW-1:0] p3);
    wait_results_done();
    cfg_write(CfgIdxW'(0), p0);
    cfg_write(CfgIdxW'(1), p1);
    cfg_write(CfgIdxW'(2), p2);
    cfg_write(CfgIdxW'(3), p3);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic test_reset_plans();
    set_idling(3, 2, 30, 4);
    send_tick(tick_of(8'd0, 5'd0, 6'd0));
    send_tick(tick_of(8'd123, 5'd23, 6'd59));
    send_tick(tick_of(8'd124, 5'd12, 6'd0));
    send_tick(tick_of(8'd255, 5'd31, 6'd63));
  endtask

  task automatic test_daily_windows();
    load_plans(make_plan(ModeWindow, 11'd480, 11'd1020, 11'd0, 11'd0),
               make_plan(ModeWindow, 11'd1320, 11'd360, 11'd7, 11'd9),
               make_plan(ModeWindow, 11'd600, 11'd600, 11'd0, 11'd0),
               make_plan(ModeWindow, 11'd1500, 11'd2047, 11'd0, 11'd0));
    set_idling(0, 1, 0, 1);
    send_tick(tick_of(8'd124, 5'd7, 6'd59));
    send_tick(tick_of(8'd124, 5'd8, 6'd0));
    send_tick(tick_of(8'd124, 5'd17, 6'd0));
    send_tick(tick_of(8'd124, 5'd22, 6'd0));
    send_tick(tick_of(8'd200, 5'd6, 6'd0));
    send_tick(tick_of(8'd124, 5'd0, 6'd0));
    send_tick(tick_of(8'd124, 5'd25, 6'd0));
    send_tick(tick_of(8'd255, 5'd31, 6'd63));
    send_tick(tick_of(8'd123, 5'd8, 6'd0));
  endtask

  task automatic test_repeat_cycles();
    load_plans(make_plan(ModeCycle, 11'd100, 11'd200, 11'd15, 11'd45),
               make_plan(ModeCycle, 11'd300, 11'd400, 11'd0, 11'd0),
               make_plan(ModeCycle, 11'd0, 11'd0, 11'd2047, 11'd2047),
               make_plan(ModeCycle, 11'd0, 11'd0, 11'd0, 11'd7));
    set_idling(5, 3, 60, 8);
    send_tick(tick_of(8'd124, 5'd0, 6'd14));
    send_tick(tick_of(8'd124, 5'd0, 6'd15));
    send_tick(tick_of(8'd124, 5'd1, 6'd0));
    send_tick(tick_of(8'd124, 5'd23, 6'd59));
    send_tick(tick_of(8'd255, 5'd31, 6'd63));
  endtask

  task automatic test_unscheduled_modes();
    load_plans('1,
               make_plan(ModeNone, '1, '1, '1, '1),
               make_plan(ModeSpare, 11'd0, 11'd1439, 11'd5, 11'd5),
               '0);
    @(posedge clk_i);
    cfg_write(CfgIdxW'(NumRelays), make_plan(ModeWindow, 11'd0, 11'd1439, 11'd0, 11'd0));
    cfg_write('1, make_plan(ModeCycle, 11'd0, 11'd0, 11'd1, 11'd1));
    cfg_valid_i <= 1'b0;
    set_idling(2, 4, 20, 3);
    send_tick(tick_of(8'd124, 5'd10, 6'd30));
    send_tick(tick_of(8'd0, 5'd31, 6'd63));
  endtask

  task automatic test_random_schedules();
    in_t tick;
    tick = tick_of(ValidYear, 5'd0, 6'd0);
    for (int phase = 0; phase < 6; phase++) begin
      load_plans(random_plan(), random_plan(), random_plan(), random_plan());
      if (phase == 0) begin
        set_idling(0, 1, 0, 1);
      end else begin
        set_idling($urandom_range(0, 15), $urandom_range(1, 8), $urandom_range(0, 70),
                   $urandom_range(1, 10));
      end
      for (int n = 0; n < 45; n++) begin
        if (phase == 2 && n == 22) wait_results_done();
        if ($urandom_range(0, 1) == 0) begin
          tick = random_tick();
        end else if (tick.minute_of_hour >= 6'd59) begin
          tick.minute_of_hour = 6'd0;
          tick.hour_of_day    = (tick.hour_of_day >= 5'd23) ? 5'd0 : tick.hour_of_day + 5'd1;
        end else begin
          tick.minute_of_hour = tick.minute_of_hour + 6'd1;
        end
        send_tick(tick);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, stall_max);
      stall_now = ($urandom_range(0, 99) < stall_pct);
    end
    stall_run--;
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_relay_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
      end else begin
        want = pending_relay_results.pop_front();
        check_field("relay_index", want.relay_index, out_data_o.relay_index);
        check_field("claimed", want.claimed, out_data_o.claimed);
        check_field("action", want.action, out_data_o.action);
        check_field("last_relay", want.last_relay, out_data_o.last_relay);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    foreach (relay_plan[r]) relay_plan[r] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_plans();
    test_daily_windows();
    test_repeat_cycles();
    test_unscheduled_modes();
    test_random_schedules();
    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rtods_pkg.sv
rtl/core/rtods_rem.sv
rtl/core/relay_time_of_day_scheduler_core.sv
test/tb_relay_time_of_day_scheduler_core.sv
